### rtl/core/message_slot_pool_with_flow_queues_defines.svh
// Assertion macros for the message slot pool.
`ifndef MESSAGE_SLOT_POOL_WITH_FLOW_QUEUES_DEFINES_SVH
`define MESSAGE_SLOT_POOL_WITH_FLOW_QUEUES_DEFINES_SVH

// Property checked only outside reset
`define MSPQ_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("slot pool check failed");

// Property that also holds across reset
`define MSPQ_CHECK_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("slot pool reset check failed");

`endif

### rtl/core/mspq_pkg.sv
// Shared types and request codes for the message slot pool.
package mspq_pkg;

   localparam int SLOT_W = 4;
   localparam int REQ_W  = 3;
   localparam int FLOW_W = 3;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ALLOC     = 3'd1;
   localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_PUSH_OUT  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_POP_OUT   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_FLUSH_OUT = 3'd5;
   localparam logic [REQ_W-1:0] REQ_PUSH_FLOW = 3'd6;
   localparam logic [REQ_W-1:0] REQ_POP_FLOW  = 3'd7;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [SLOT_W-1:0] slot;
      logic [FLOW_W-1:0] flow;
   } mspq_req_type;

   typedef struct packed {
      logic              alloc_ok;
      logic [SLOT_W-1:0] alloc_slot;
      logic              push_dropped;
      logic              out_pending;
      logic [SLOT_W-1:0] out_head;
      logic              flow_pending;
      logic [SLOT_W-1:0] flow_head;
   } mspq_rsp_type;

   // Queue command for one step
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } mspq_qcmd_type;

   // Queue status: before the step and after it
   typedef struct packed {
      logic              full;
      logic              pending;
      logic [SLOT_W-1:0] head;
      logic              pending_next;
      logic [SLOT_W-1:0] head_next;
   } mspq_qstat_type;

   // Free map request for one step
   typedef struct packed {
      logic              alloc;
      logic              free_en;
      logic [SLOT_W-1:0] free_slot;
   } mspq_pool_req_type;

endpackage

### rtl/core/mspq_queue.sv
// Slot index FIFO: head register in front of a ring memory with look-ahead read.
module mspq_queue #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mspq_pkg::mspq_qcmd_type    cmd,
   input  logic [mspq_pkg::SLOT_W-1:0] push_slot,
   output mspq_pkg::mspq_qstat_type   stat
);
   import mspq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]     count_ff, count_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [AW-1:0]     mrd_ff, mrd_in;
   logic [AW-1:0]     mwr_ff, mwr_in;
   logic [SLOT_W-1:0] rdata_ff;
   logic [SLOT_W-1:0] mem [DEPTH];
   logic              wr_en;
   logic              empty;
   logic              full;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));

   // Next state: entries behind the head live in the memory
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      mrd_in   = mrd_ff;
      mwr_in   = mwr_ff;
      wr_en    = 1'b0;
      if (cmd.flush) begin
         count_in = '0;
         mrd_in   = mwr_ff;
      end else if (cmd.push && !full) begin
         count_in = count_ff + CW'(1);
         if (empty) begin
            head_in = push_slot;
         end else begin
            wr_en  = 1'b1;
            mwr_in = ptr_inc(mwr_ff);
         end
      end else if (cmd.pop && !empty) begin
         count_in = count_ff - CW'(1);
         if (count_ff > CW'(1)) begin
            head_in = rdata_ff;
            mrd_in  = ptr_inc(mrd_ff);
         end
      end
   end

   // Status before and after the step
   always_comb begin
      stat.full         = full;
      stat.pending      = !empty;
      stat.head         = head_ff;
      stat.pending_next = (count_in != '0);
      stat.head_next    = (count_in != '0) ? head_in : '0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mrd_ff   <= '0;
         mwr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         mrd_ff   <= mrd_in;
         mwr_ff   <= mwr_in;
      end
   end

   // Head register
   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

   // Ring memory; read data tracks the oldest stored entry, write bypassed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[mwr_ff] <= push_slot;
      end
      if (wr_en && (mwr_ff == mrd_in)) begin
         rdata_ff <= push_slot;
      end else begin
         rdata_ff <= mem[mrd_in];
      end
   end

endmodule

### rtl/core/mspq_pool.sv
// Free map of the slot pool with lowest-free-slot allocation.
module mspq_pool #(
   parameter int POOL_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mspq_pkg::mspq_pool_req_type   req,
   output logic                          alloc_ok,
   output logic [mspq_pkg::SLOT_W-1:0]   alloc_slot
);
   import mspq_pkg::*;

   localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

   logic [POOL_SLOTS-1:0] free_map_ff, free_map_in;
   logic [POOL_SLOTS-1:0] lowest;
   logic [POOL_SLOTS-1:0] free_vec;
   logic [SW-1:0]         idx;
   logic                  any_free;

   // Isolate the lowest free slot and encode it
   always_comb begin
      any_free = |free_map_ff;
      lowest   = free_map_ff & (~free_map_ff + POOL_SLOTS'(1));
      idx      = '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         if (lowest[i]) begin
            idx = idx | SW'(i);
         end
      end
   end

   assign alloc_ok   = req.alloc && any_free;
   assign alloc_slot = alloc_ok ? SLOT_W'(idx) : '0;

   // Slot returned by release or by a queue pop; out-of-range frees nothing
   always_comb begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
         free_vec[i] = req.free_en && (int'(req.free_slot) == i);
      end
   end

   always_comb begin
      free_map_in = free_map_ff | free_vec;
      if (alloc_ok) begin
         free_map_in = free_map_ff & ~lowest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= '1;
      end else begin
         free_map_ff <= free_map_in;
      end
   end

endmodule

### rtl/core/message_slot_pool_with_flow_queues.sv
// Top level of the message slot pool with output and per-flow queues.
// Takes one request item per cycle and presents one result item per request: the item
// is registered on entry, the free map and all queues are updated in a single pass, and
// the result is registered on exit. A result held by the receiver stalls the input once
// the entry register is also occupied. Each queue keeps its head slot in a register and
// reads the next entry ahead from its ring memory, so back-to-back pops run at full rate;
// the lowest-free-slot search is one priority encoder over the free map. Reported queue
// state is that after the request.
`include "message_slot_pool_with_flow_queues_defines.svh"

module message_slot_pool_with_flow_queues #(
   parameter int POOL_SLOTS = 16,
   parameter int OUT_DEPTH  = 16,
   parameter int FLOW_DEPTH = 16,
   parameter int FLOW_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mspq_pkg::mspq_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mspq_pkg::mspq_rsp_type rsp_data
);
   import mspq_pkg::*;

   logic              in_valid_ff;
   mspq_req_type      in_item_ff;
   logic              rsp_valid_ff;
   mspq_rsp_type      rsp_item_ff, rsp_item_in;
   logic              fire;
   logic              flow_ok;
   logic [FLOW_COUNT-1:0] flow_sel;

   mspq_qcmd_type     out_cmd;
   mspq_qstat_type    out_stat;
   mspq_qcmd_type     flow_cmd  [FLOW_COUNT];
   mspq_qstat_type    flow_stat [FLOW_COUNT];
   mspq_qstat_type    sel_stat;
   mspq_pool_req_type pool_req;
   logic              alloc_ok;
   logic [SLOT_W-1:0] alloc_slot;

   // Handshake: process when the result register is free or being drained
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   // Flow decode
   always_comb begin
      flow_ok = (int'(in_item_ff.flow) < FLOW_COUNT);
      for (int g = 0; g < FLOW_COUNT; g++) begin
         flow_sel[g] = (int'(in_item_ff.flow) == g);
      end
   end

   // Selected flow status
   always_comb begin
      sel_stat = '0;
      for (int g = 0; g < FLOW_COUNT; g++) begin
         if (flow_sel[g]) begin
            sel_stat = flow_stat[g];
         end
      end
   end

   // Queue commands
   always_comb begin
      out_cmd.push  = fire && (in_item_ff.req_type == REQ_PUSH_OUT);
      out_cmd.pop   = fire && (in_item_ff.req_type == REQ_POP_OUT);
      out_cmd.flush = fire && (in_item_ff.req_type == REQ_FLUSH_OUT);
      for (int g = 0; g < FLOW_COUNT; g++) begin
         flow_cmd[g].push  = fire && flow_sel[g] && (in_item_ff.req_type == REQ_PUSH_FLOW);
         flow_cmd[g].pop   = fire && flow_sel[g] && (in_item_ff.req_type == REQ_POP_FLOW);
         flow_cmd[g].flush = 1'b0;
      end
   end

   // Free map request: allocate, release, or free a popped head slot
   always_comb begin
      pool_req           = '0;
      pool_req.free_slot = in_item_ff.slot;
      if (fire) begin
         case (in_item_ff.req_type)
            REQ_ALLOC: begin
               pool_req.alloc = 1'b1;
            end
            REQ_RELEASE: begin
               pool_req.free_en = 1'b1;
            end
            REQ_POP_OUT: begin
               pool_req.free_en   = out_stat.pending;
               pool_req.free_slot = out_stat.head;
            end
            REQ_POP_FLOW: begin
               pool_req.free_en   = flow_ok && sel_stat.pending;
               pool_req.free_slot = sel_stat.head;
            end
            default: begin
               pool_req.alloc = 1'b0;
            end
         endcase
      end
   end

   mspq_pool #(
      .POOL_SLOTS(POOL_SLOTS)
   ) u_pool (
      .clock     (clock),
      .reset     (reset),
      .req       (pool_req),
      .alloc_ok  (alloc_ok),
      .alloc_slot(alloc_slot)
   );

   mspq_queue #(
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd      (out_cmd),
      .push_slot(in_item_ff.slot),
      .stat     (out_stat)
   );

   for (genvar g = 0; g < FLOW_COUNT; g++) begin : g_flow
      mspq_queue #(
         .DEPTH(FLOW_DEPTH)
      ) u_flow_queue (
         .clock    (clock),
         .reset    (reset),
         .cmd      (flow_cmd[g]),
         .push_slot(in_item_ff.slot),
         .stat     (flow_stat[g])
      );
   end

   // Result item
   always_comb begin
      rsp_item_in.alloc_ok     = alloc_ok;
      rsp_item_in.alloc_slot   = alloc_slot;
      rsp_item_in.push_dropped =
         ((in_item_ff.req_type == REQ_PUSH_OUT) && out_stat.full) ||
         ((in_item_ff.req_type == REQ_PUSH_FLOW) && flow_ok && sel_stat.full);
      rsp_item_in.out_pending  = out_stat.pending_next;
      rsp_item_in.out_head     = out_stat.head_next;
      rsp_item_in.flow_pending = flow_ok && sel_stat.pending_next;
      rsp_item_in.flow_head    = flow_ok ? sel_stat.head_next : '0;
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Checks
   `MSPQ_CHECK(a_fire_gives_result, fire |=> rsp_valid)
   `MSPQ_CHECK(a_alloc_only_on_alloc,
      (fire && (in_item_ff.req_type != REQ_ALLOC)) |=> !rsp_data.alloc_ok)
   `MSPQ_CHECK(a_flush_empties_out,
      (fire && (in_item_ff.req_type == REQ_FLUSH_OUT)) |=> !rsp_data.out_pending)
   `MSPQ_CHECK_RST(a_reset_clears_result, reset |=> !rsp_valid)

endmodule
